// ===== hdl/edpt_pkg.sv =====
// ----------------------------------------------------------------------------
// edpt_pkg
// Shared types, codes and widths for the Euler degree parity tracker.
// ----------------------------------------------------------------------------
package edpt_pkg;

  localparam int VERTEX_W             = 4;
  localparam int VCOUNT_W             = 5;
  localparam int ODD_W                = 5;
  localparam int EDGE_W               = 8;
  localparam int CLASS_W              = 2;
  // compare width for vertex index against the limit (holds up to 255)
  localparam int CMP_W                = 8;
  localparam int DEFAULT_MAX_VERTICES = 16;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_CIRCUIT = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_PATH    = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd2;

  typedef struct packed {
    logic                op;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] euler_class;
    logic [ODD_W-1:0]   odd_vertex_total;
    logic [EDGE_W-1:0]  edge_total;
    logic               range_error;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic mem_rd;   // read the row of the request being accepted
    logic commit;   // write back, update degree state, load result
  } ctrl_t;

  function automatic logic [CLASS_W-1:0] class_of(input logic [ODD_W-1:0] odd);
    logic [CLASS_W-1:0] cls;
    priority if (odd == '0) begin
      cls = CLASS_CIRCUIT;
    end else if (odd <= ODD_W'(2)) begin
      cls = CLASS_PATH;
    end else begin
      cls = CLASS_NONE;
    end
    return cls;
  endfunction

endpackage

// ===== hdl/edpt_ram.sv =====
// ----------------------------------------------------------------------------
// edpt_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module edpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/edpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// edpt_ctrl
// Request sequencer: row read on accept, write back and result load once the result register is free.
// ----------------------------------------------------------------------------
module edpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           out_busy,
  output logic           item_ready,
  output edpt_pkg::ctrl_t ctrl
);

  edpt_pkg::state_t state;
  edpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      edpt_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = edpt_pkg::ST_LOOK;
        end
      end
      edpt_pkg::ST_LOOK: begin
        // hold until the result register can take the answer
        if (!out_busy) begin
          state_next = edpt_pkg::ST_IDLE;
        end
      end
      default: state_next = edpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = 1'b0;
    ctrl.mem_rd = 1'b0;
    ctrl.commit = 1'b0;
    unique case (state)
      edpt_pkg::ST_IDLE: begin
        item_ready  = 1'b1;
        ctrl.mem_rd = item_valid;
      end
      edpt_pkg::ST_LOOK: begin
        ctrl.commit = !out_busy;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/edpt_degree.sv =====
// ----------------------------------------------------------------------------
// edpt_degree
// Degree parity vector, odd-vertex count and edge count.
// ----------------------------------------------------------------------------
module edpt_degree #(
  parameter int MAX_VERTICES = edpt_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          update,
  input  logic                          op,
  input  logic [edpt_pkg::VERTEX_W-1:0] vertex_a,
  input  logic [edpt_pkg::VERTEX_W-1:0] vertex_b,
  output logic [edpt_pkg::ODD_W-1:0]    odd_after,
  output logic [edpt_pkg::EDGE_W-1:0]   edge_after
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0]       parity;
  logic [MAX_VERTICES-1:0]       parity_next;
  logic [edpt_pkg::ODD_W-1:0]    odd_total;
  logic [edpt_pkg::EDGE_W-1:0]   edge_count;
  logic [AW-1:0]                 idx_a;
  logic [AW-1:0]                 idx_b;
  logic                          self_loop;
  logic [edpt_pkg::ODD_W-1:0]    step_a;
  logic [edpt_pkg::ODD_W-1:0]    step_b;
  logic [MAX_VERTICES-1:0]       flip;

  assign idx_a     = AW'(vertex_a);
  assign idx_b     = AW'(vertex_b);
  assign self_loop = (vertex_a == vertex_b);

  // odd vertex gains one when its parity was even, loses one when odd
  assign step_a = parity[idx_a] ? '1 : edpt_pkg::ODD_W'(1);
  assign step_b = self_loop ? '0 : (parity[idx_b] ? '1 : edpt_pkg::ODD_W'(1));

  assign flip = (MAX_VERTICES'(1) << idx_a)
              ^ (self_loop ? '0 : (MAX_VERTICES'(1) << idx_b));

  always_comb begin
    if (update) begin
      parity_next = parity ^ flip;
      odd_after   = odd_total + step_a + step_b;
      edge_after  = (op == edpt_pkg::OP_ADD) ? edge_count + edpt_pkg::EDGE_W'(1)
                                             : edge_count - edpt_pkg::EDGE_W'(1);
    end else begin
      parity_next = parity;
      odd_after   = odd_total;
      edge_after  = edge_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      parity     <= '0;
      odd_total  <= '0;
      edge_count <= '0;
    end else begin
      parity     <= parity_next;
      odd_total  <= odd_after;
      edge_count <= edge_after;
    end
  end

endmodule

// ===== hdl/euler_degree_parity_tracker.sv =====
// ----------------------------------------------------------------------------
// euler_degree_parity_tracker
// Edge add/remove requests on an undirected graph; reports the Euler class.
// ----------------------------------------------------------------------------
// Each request adds or removes one edge and returns one result: the Euler
// class from the number of odd-degree vertices (none: circuit and path, one
// or two: path only, more: neither), that count, the number of distinct
// edges, and a range flag. Connectivity is not checked. The adjacency row
// is read from the RAM in the accept cycle and written back from ST_LOOK,
// so a new request is not accepted until the last one is written back.
// The result register frees the input side; a request whose result finds
// that register still full waits in ST_LOOK until the result is
// taken. Only one triangle of the symmetric matrix is stored: row
// min(from,to), bit max(from,to), so one read-modify-write covers an edge.
// A self-loop flips the parity of its vertex once. Adding a present edge or
// removing an absent one changes nothing. An endpoint at or above
// min(vertex_count, MAX_VERTICES) sets range_error and leaves the graph as
// it is. Rows carry valid bits, so reset and a vertex_count write clear the
// graph with no clearing pass; vertex_count may be written only while no
// request is in flight.
module euler_degree_parity_tracker #(
  parameter int MAX_VERTICES = edpt_pkg::DEFAULT_MAX_VERTICES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [edpt_pkg::VCOUNT_W-1:0] cfg_vertex_count,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  edpt_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output edpt_pkg::result_t             result
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic [edpt_pkg::VCOUNT_W-1:0] vertex_count;
  edpt_pkg::item_t               held;
  logic [MAX_VERTICES-1:0]       row_valid;
  edpt_pkg::ctrl_t               ctrl;
  logic                          out_busy;
  logic                          cfg_write;

  logic [edpt_pkg::VERTEX_W-1:0] in_lo;
  logic [edpt_pkg::VERTEX_W-1:0] lo;
  logic [edpt_pkg::VERTEX_W-1:0] hi;
  logic [AW-1:0]                 lo_idx;
  logic [AW-1:0]                 hi_idx;
  logic [MAX_VERTICES-1:0]       rdata;
  logic [MAX_VERTICES-1:0]       row_word;
  logic [MAX_VERTICES-1:0]       row_new;
  logic [edpt_pkg::CMP_W-1:0]    limit;
  logic                          range_err;
  logic                          present;
  logic                          want;
  logic                          change;
  logic                          mem_we;
  logic [edpt_pkg::ODD_W-1:0]    odd_after;
  logic [edpt_pkg::EDGE_W-1:0]   edge_after;

  // config: always takes the write, clears the graph
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= edpt_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_vertex_count;
    end
  end

  assign out_busy = result_valid && !result_ready;

  edpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .out_busy   (out_busy),
    .item_ready (item_ready),
    .ctrl       (ctrl)
  );

  // hold the accepted request for ST_LOOK
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  // stored triangle: row is the lower endpoint
  assign in_lo = (item.from_vertex < item.to_vertex) ? item.from_vertex : item.to_vertex;
  assign lo    = (held.from_vertex < held.to_vertex) ? held.from_vertex : held.to_vertex;
  assign hi    = (held.from_vertex < held.to_vertex) ? held.to_vertex : held.from_vertex;
  assign lo_idx = AW'(lo);
  assign hi_idx = AW'(hi);

  edpt_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj (
    .clk   (clk),
    .we    (mem_we),
    .waddr (lo_idx),
    .wdata (row_new),
    .re    (ctrl.mem_rd),
    .raddr (AW'(in_lo)),
    .rdata (rdata)
  );

  // vertex limit saturates at MAX_VERTICES
  assign limit = (edpt_pkg::CMP_W'(vertex_count) > edpt_pkg::CMP_W'(MAX_VERTICES))
               ? edpt_pkg::CMP_W'(MAX_VERTICES) : edpt_pkg::CMP_W'(vertex_count);

  assign range_err = (edpt_pkg::CMP_W'(held.from_vertex) >= limit)
                  || (edpt_pkg::CMP_W'(held.to_vertex) >= limit);

  // a row never written since the last clear reads as empty
  assign row_word = row_valid[lo_idx] ? rdata : '0;
  assign present  = row_word[hi_idx];
  assign want     = (held.op == edpt_pkg::OP_ADD);
  assign change   = !range_err && (present != want);

  always_comb begin
    row_new         = row_word;
    row_new[hi_idx] = want;
  end

  assign mem_we = ctrl.commit && change;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[lo_idx] <= 1'b1;
    end
  end

  edpt_degree #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_degree (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_write),
    .update     (mem_we),
    .op         (held.op),
    .vertex_a   (held.from_vertex),
    .vertex_b   (held.to_vertex),
    .odd_after  (odd_after),
    .edge_after (edge_after)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      result.euler_class      <= edpt_pkg::class_of(odd_after);
      result.odd_vertex_total <= odd_after;
      result.edge_total       <= edge_after;
      result.range_error      <= range_err;
    end
  end

  // an out-of-range request never touches the matrix
  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !range_err)
    else $error("adjacency write on a range error");

  // an accepted request occupies the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted back to back");

  // a commit never overwrites an untaken result
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit |-> !out_busy)
    else $error("result overwritten before taken");

  // a config write empties the matrix
  a_cfg_clears_rows: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> row_valid == '0)
    else $error("rows still valid after config write");

endmodule
